@@ sv/sha256_stream_hasher_top_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define SHS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha256 stream hasher check failed");

// Next-cycle implication, sampled on clk, idle during reset
`define SHS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha256 stream hasher check failed");

`endif

@@ sv/shs_pkg.sv @@
package shs_pkg;

	// control for one chain cell
	typedef struct packed {
		logic byte_shift;
		logic word_shift;
	} shs_shift_t;

	typedef logic [7:0][31:0] shs_words8_t;

	localparam logic [5:0] SHS_LEN_OFFSET = 6'd56;
	localparam logic [5:0] SHS_LAST_BYTE  = 6'd63;
	localparam logic [7:0] SHS_PAD_MARK   = 8'h80;

	// initial hash value, entry 0 is H0
	localparam shs_words8_t SHS_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] SHS_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// schedule sigmas
	function automatic logic [31:0] shs_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] shs_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	// round sigmas
	function automatic logic [31:0] shs_bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] shs_bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] shs_ch(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		return (x & y) ^ (~x & z);
	endfunction

	function automatic logic [31:0] shs_maj(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		return (x & y) ^ (x & z) ^ (y & z);
	endfunction

endpackage

@@ sv/shs_cell.sv @@
// One 32-bit cell of a chain: takes a byte or a whole word from its neighbor.
module shs_cell (
	input  logic               clk,
	input  shs_pkg::shs_shift_t shift,
	input  logic [31:0]        nb_word,
	output logic [31:0]        q
);
	import shs_pkg::*;

	logic [31:0] word_q;

	always_ff @(posedge clk) begin
		if (shift.word_shift) begin
			word_q <= nb_word;
		end else if (shift.byte_shift) begin
			word_q <= {word_q[23:0], nb_word[31:24]};
		end
	end

	assign q = word_q;
endmodule

@@ sv/shs_sched.sv @@
// Message block and rolling schedule: 16 cells, w[0] is the current round word.
module shs_sched (
	input  logic        clk,
	input  logic        byte_en,
	input  logic [7:0]  byte_in,
	input  logic        word_en,
	output logic [31:0] wt
);
	import shs_pkg::*;

	logic [15:0][31:0] w;
	logic [15:0][31:0] nb;
	logic [31:0]       w_next;
	shs_shift_t        ctl;

	assign ctl.byte_shift = byte_en;
	assign ctl.word_shift = word_en;

	// W[t+16] from the window W[t..t+15]
	assign w_next = shs_sig1(w[14]) + w[9] + shs_sig0(w[1]) + w[0];

	always_comb begin
		for (int i = 0; i < 15; i++) begin
			nb[i] = w[i+1];
		end
		nb[15] = word_en ? w_next : {byte_in, 24'd0};
	end

	for (genvar i = 0; i < 16; i++) begin : g_cell
		shs_cell u_cell (
			.clk     (clk),
			.shift   (ctl),
			.nb_word (nb[i]),
			.q       (w[i])
		);
	end

	assign wt = w[0];
endmodule

@@ sv/shs_round.sv @@
// Working variables a..h as a chain of 8 cells, one round per step.
module shs_round (
	input  logic                clk,
	input  logic                load,
	input  logic                step,
	input  shs_pkg::shs_words8_t init_hash,
	input  logic [31:0]         kt,
	input  logic [31:0]         wt,
	output shs_pkg::shs_words8_t vars
);
	import shs_pkg::*;

	shs_words8_t v;
	shs_words8_t nb;
	logic [31:0] t1;
	logic [31:0] t2;
	shs_shift_t  ctl;

	assign ctl.byte_shift = 1'b0;
	assign ctl.word_shift = load | step;

	assign t1 = v[7] + shs_bsig1(v[4]) + shs_ch(v[4], v[5], v[6]) + kt + wt;
	assign t2 = shs_bsig0(v[0]) + shs_maj(v[0], v[1], v[2]);

	// each cell takes its left neighbor, a and e take the round sums
	always_comb begin
		for (int i = 1; i < 8; i++) begin
			nb[i] = v[i-1];
		end
		nb[0] = t1 + t2;
		nb[4] = v[3] + t1;
		if (load) begin
			nb = init_hash;
		end
	end

	for (genvar i = 0; i < 8; i++) begin : g_cell
		shs_cell u_cell (
			.clk     (clk),
			.shift   (ctl),
			.nb_word (nb[i]),
			.q       (v[i])
		);
	end

	assign vars = v;
endmodule

@@ sv/sha256_stream_hasher_top.sv @@
// Absorb byte: the byte that fills a 64-byte block then holds s_tready low
// for the 64 rounds at one per cycle and the hash update.
// Finish: 9 to 72 internal padding bytes, each block filled on the way adding its
// rounds and update, then eight output words, one per cycle while m_tready is high.
// Reset (arst_n low, asynchronous): hash state to the initial value, counters cleared.
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast
);
	import shs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_RUN  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	shs_words8_t hash_q;
	logic [5:0]  fill_q;
	logic [63:0] msg_bits_q;
	logic [63:0] len_q;
	logic        fin_q;
	logic        mark_q;
	logic        lphase_q;
	logic [2:0]  lcnt_q;
	logic        done_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;

	logic        in_hs;
	logic        out_hs;
	logic        push_en;
	logic [7:0]  push_byte;
	logic        use_len;
	logic        vload;
	logic        vstep;
	logic [31:0] wt;
	shs_words8_t vars;

	assign in_hs  = s_tvalid & s_tready;
	assign out_hs = m_tvalid & m_tready;

	// padding byte: marker, zeros to offset 56, then length high byte first
	assign use_len = mark_q & (lphase_q | (fill_q == SHS_LEN_OFFSET));

	always_comb begin
		push_en   = 1'b0;
		push_byte = s_tdata;
		if (state_q == ST_IDLE) begin
			push_en = in_hs & ~s_tuser;
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			if (!mark_q) begin
				push_byte = SHS_PAD_MARK;
			end else if (use_len) begin
				push_byte = len_q[63:56];
			end else begin
				push_byte = 8'h00;
			end
		end
	end

	assign vload = push_en & (fill_q == SHS_LAST_BYTE);
	assign vstep = (state_q == ST_RUN);

	shs_sched u_sched (
		.clk     (clk),
		.byte_en (push_en),
		.byte_in (push_byte),
		.word_en (vstep),
		.wt      (wt)
	);

	shs_round u_round (
		.clk       (clk),
		.load      (vload),
		.step      (vstep),
		.init_hash (hash_q),
		.kt        (SHS_K[rnd_q]),
		.wt        (wt),
		.vars      (vars)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hash_q     <= SHS_IV;
			fill_q     <= 6'd0;
			msg_bits_q <= 64'd0;
			len_q      <= 64'd0;
			fin_q      <= 1'b0;
			mark_q     <= 1'b0;
			lphase_q   <= 1'b0;
			lcnt_q     <= 3'd0;
			done_q     <= 1'b0;
			rnd_q      <= 6'd0;
			oidx_q     <= 3'd0;
		end else begin
			if (push_en) begin
				fill_q     <= fill_q + 6'd1;
				msg_bits_q <= msg_bits_q + 64'd8;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_hs && s_tuser) begin
						len_q    <= msg_bits_q;
						fin_q    <= 1'b1;
						mark_q   <= 1'b0;
						lphase_q <= 1'b0;
						lcnt_q   <= 3'd0;
						done_q   <= 1'b0;
						state_q  <= ST_PAD;
					end else if (vload) begin
						rnd_q   <= 6'd0;
						state_q <= ST_RUN;
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					if (use_len) begin
						lphase_q <= 1'b1;
						len_q    <= {len_q[55:0], 8'h00};
						lcnt_q   <= lcnt_q + 3'd1;
						if (lcnt_q == 3'd7) begin
							done_q <= 1'b1;
						end
					end
					if (vload) begin
						rnd_q   <= 6'd0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + vars[i];
					end
					if (done_q) begin
						oidx_q  <= 3'd0;
						state_q <= ST_OUT;
					end else if (fin_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_hs) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							hash_q     <= SHS_IV;
							fill_q     <= 6'd0;
							msg_bits_q <= 64'd0;
							fin_q      <= 1'b0;
							done_q     <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = hash_q[oidx_q];
	assign m_tuser  = oidx_q;
	assign m_tlast  = (oidx_q == 3'd7);
endmodule

@@ sv/sha256_stream_hasher_checker.sv @@
`include "sha256_stream_hasher_top_macros.svh"

// Port-level checks on the hasher.
module sha256_stream_hasher_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	// a stalled digest word holds
	`SHS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// last flag marks word seven exactly
	`SHS_ASSERT_NOW(a_last_idx, m_tvalid, m_tlast == (m_tuser == 3'd7))
	// no input taken while a digest is being sent
	`SHS_ASSERT_NOW(a_no_in_during_out, m_tvalid, !s_tready)
	// digest words advance one index per taken word
	`SHS_ASSERT_NEXT(a_idx_step, m_tvalid && m_tready && !m_tlast,
		m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
	// after the last word the block is ready for a new message
	`SHS_ASSERT_NEXT(a_back_idle, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready)
endmodule

bind sha256_stream_hasher_top sha256_stream_hasher_sva u_checker (.*);
